@@ sv/gbc_pkg.sv @@
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types and constants for the gyro bias calibration and range check.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 20;
  localparam int LIMIT_W  = 15;
  localparam int FAIL_W   = 8;
  localparam int AXES     = 3;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [LIMIT_W-1:0] RANGE_LIMIT_RST = 15'd30000;
  localparam logic [FAIL_W-1:0]  FAIL_LIMIT_RST  = 8'd5;
  localparam logic [FAIL_W-1:0]  REJECT_MAX      = 8'd255;

  // register index, taken from the word address
  typedef enum logic {
    REG_RANGE_LIMIT = 1'b0,
    REG_FAIL_LIMIT  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CAL  = 2'd1,
    ST_WARN = 2'd2,
    ST_FAIL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_CAL,
    PH_MUL,
    PH_FIX,
    PH_RUN
  } phase_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

@@ sv/gbc_sample_if.sv @@
// ----------------------------------------------------------------------------
// gbc_sample_if
// Raw three-axis gyro sample channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gbc_sample_if;
  import gbc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t raw_x;
  sample_t raw_y;
  sample_t raw_z;

  modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

@@ sv/gbc_rate_if.sv @@
// ----------------------------------------------------------------------------
// gbc_rate_if
// Corrected rate and status channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gbc_rate_if;
  import gbc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t rate_x;
  sample_t rate_y;
  sample_t rate_z;
  status_e status;

  modport source (output valid, output rate_x, output rate_y, output rate_z,
                  output status, input ready);
  modport sink   (input valid, input rate_x, input rate_y, input rate_z,
                  input status, output ready);
endinterface

@@ sv/gyro_bias_cal_range_check.sv @@
// ----------------------------------------------------------------------------
// gyro_bias_cal_range_check
// Per-sample offset removal and range check with start-up bias calibration.
// ----------------------------------------------------------------------------
// an accepted sample's result is in the output register in the following cycle
// throughput: one sample per cycle unless the output is held; after the last
//   calibration sample, the input stalls once for the bias quotient multiply
// reset: offsets, sums, held rates and reject count clear, limits take defaults,
//   calibration restarts with its discard sample
module gyro_bias_cal_range_check #(
  parameter int CAL_SAMPLES = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gbc_sample_if.sink                  sample_i,
  gbc_rate_if.source                  rate_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gbc_pkg::APB_AW-1:0]  paddr,
  input  logic [gbc_pkg::APB_DW-1:0]  pwdata,
  output logic [gbc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import gbc_pkg::*;

  localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
  localparam int DIV_SH  = SUM_W + $clog2(CAL_SAMPLES);
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  // ceil(2^DIV_SH / CAL_SAMPLES): exact quotient for any 20-bit magnitude
  localparam longint RECIP_L = ((64'd1 << DIV_SH) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  // configuration
  logic [LIMIT_W-1:0] range_q;
  logic [FAIL_W-1:0]  fail_q;
  logic               cfg_wr;

  // datapath state
  phase_e                          phase_q, phase_d;
  logic [AXES-1:0][SAMPLE_W-1:0]   offset_q;
  logic [AXES-1:0][SUM_W-1:0]      sum_q;
  logic [AXES-1:0][PROD_W-1:0]     prod_q;
  logic [AXES-1:0][SAMPLE_W-1:0]   held_q;
  logic [CNT_W-1:0]                cnt_q;
  logic [FAIL_W-1:0]               rej_q;
  status_e                         status_q;
  logic                            out_valid_q;

  logic                            accept;
  logic [AXES-1:0][SAMPLE_W-1:0]   raw;
  logic [AXES-1:0][SAMPLE_W-1:0]   corr;
  logic [AXES-1:0][SUM_W-1:0]      sum_next;
  logic [AXES-1:0][SUM_W-1:0]      mag;
  logic [AXES-1:0][SAMPLE_W-1:0]   quot;
  logic [AXES-1:0]                 axis_bad;
  logic                            any_bad;
  logic [FAIL_W-1:0]               rej_inc;
  logic                            cal_last;
  logic                            busy;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_idx_e'(paddr[2]))
      REG_RANGE_LIMIT: prdata = APB_DW'(range_q);
      REG_FAIL_LIMIT:  prdata = APB_DW'(fail_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RANGE_LIMIT_RST;
      fail_q  <= FAIL_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_RANGE_LIMIT: range_q <= pwdata[LIMIT_W-1:0];
        REG_FAIL_LIMIT:  fail_q  <= pwdata[FAIL_W-1:0];
        default:         range_q <= range_q;
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign busy           = (phase_q == PH_MUL) || (phase_q == PH_FIX);
  assign sample_i.ready = !busy && (!out_valid_q || rate_o.ready);
  assign accept         = sample_i.valid && sample_i.ready;

  assign rate_o.valid  = out_valid_q;
  assign rate_o.rate_x = held_q[0];
  assign rate_o.rate_y = held_q[1];
  assign rate_o.rate_z = held_q[2];
  assign rate_o.status = status_q;

  // ---------------- per-sample logic ----------------
  assign raw[0] = sample_i.raw_x;
  assign raw[1] = sample_i.raw_y;
  assign raw[2] = sample_i.raw_z;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      corr[a]     = raw[a] - offset_q[a];
      sum_next[a] = sum_q[a] + {{(SUM_W-SAMPLE_W){corr[a][SAMPLE_W-1]}}, corr[a]};
      mag[a]      = sum_q[a][SUM_W-1] ? (~sum_q[a] + 1'b1) : sum_q[a];
      quot[a]     = prod_q[a][DIV_SH +: SAMPLE_W];
      axis_bad[a] = ($signed({corr[a][SAMPLE_W-1], corr[a]}) >
                     $signed({2'b00, range_q})) ||
                    ($signed({corr[a][SAMPLE_W-1], corr[a]}) <
                     -$signed({2'b00, range_q}));
    end
  end

  assign any_bad  = |axis_bad;
  assign rej_inc  = (rej_q == REJECT_MAX) ? rej_q : rej_q + 1'b1;
  assign cal_last = (cnt_q == CNT_W'(CAL_SAMPLES));

  // ---------------- phase control ----------------
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_CAL: if (accept && cal_last) phase_d = PH_MUL;
      PH_MUL: phase_d = PH_FIX;
      PH_FIX: phase_d = PH_RUN;
      PH_RUN: phase_d = PH_RUN;
      default: phase_d = PH_CAL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CAL;
    end else begin
      phase_q <= phase_d;
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      sum_q       <= '0;
      held_q      <= '0;
      cnt_q       <= '0;
      rej_q       <= '0;
      status_q    <= ST_CAL;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (rate_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (phase_q)
        PH_CAL: begin
          if (accept) begin
            status_q <= ST_CAL;
            // first sample after reset is dropped
            if (cnt_q != '0) begin
              sum_q <= sum_next;
            end
            cnt_q <= cnt_q + 1'b1;
          end
        end
        PH_MUL: begin
          // product register is loaded below
        end
        PH_FIX: begin
          for (int a = 0; a < AXES; a++) begin
            offset_q[a] <= offset_q[a] + (sum_q[a][SUM_W-1] ? (~quot[a] + 1'b1) : quot[a]);
          end
          sum_q <= '0;
          cnt_q <= '0;
        end
        PH_RUN: begin
          if (accept) begin
            if (any_bad) begin
              rej_q    <= rej_inc;
              status_q <= (rej_inc >= fail_q) ? ST_FAIL : ST_WARN;
            end else begin
              held_q   <= corr;
              rej_q    <= '0;
              status_q <= ST_OK;
            end
          end
        end
        default: begin
          status_q <= status_q;
        end
      endcase
    end
  end

  // magnitude times reciprocal, one register per axis
  always_ff @(posedge clk_i) begin
    if (phase_q == PH_MUL) begin
      for (int a = 0; a < AXES; a++) begin
        prod_q[a] <= PROD_W'(mag[a]) * PROD_W'(RECIP);
      end
    end
  end

  // ---------------- assertions ----------------
  a_no_accept_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sample_i.ready && (phase_q == PH_MUL || phase_q == PH_FIX)))
    else $error("sample accepted during bias division");

  a_mul_then_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_MUL |=> phase_q == PH_FIX)
    else $error("bias division skipped a step");

  a_offset_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RUN && $past(phase_q) == PH_RUN) |-> $stable(offset_q))
    else $error("offset changed after calibration");

  a_ok_clears_rejects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rate_o.valid && rate_o.status == ST_OK) |-> rej_q == '0)
    else $error("reject count not cleared on accepted sample");

endmodule
